// ----- rtl/core/set_assoc_cache_tag_store_defines.svh -----
// assertion macros used by the tag store back end
`ifndef SET_ASSOC_CACHE_TAG_STORE_DEFINES_SVH
`define SET_ASSOC_CACHE_TAG_STORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define SACTS_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SACTS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/sacts_pkg.sv -----
`default_nettype none
package sacts_pkg;

    localparam int ADDR_W     = 32;
    localparam int STAMP_W    = 32;
    localparam int CNT_W      = 32;
    localparam int PICK_W     = 16;
    localparam int SET_CNT_W  = 11;
    localparam int WAY_CNT_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int DIGIT_BITS = 4;
    localparam int DIV_STEPS  = ADDR_W / DIGIT_BITS;

    localparam logic OP_LOOKUP  = 1'b0;
    localparam logic OP_INSTALL = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_COUNT      = 2'd0,
        CFG_WAY_COUNT      = 2'd1,
        CFG_RANDOM_REPLACE = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic                opcode;
        logic [ADDR_W-1:0]   line_addr;
        logic                dirty_flag;
        logic [STAMP_W-1:0]  time_stamp;
    } req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/sacts_front.sv -----
`default_nettype none
module sacts_front #(
    parameter int MAX_SETS  = 1024,
    parameter int MAX_ASSOC = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1):0]   sets_use,
    input  wire logic [((MAX_ASSOC > 1) ? $clog2(MAX_ASSOC) : 1):0] ways_use,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire sacts_pkg::req_t                     in_req,
    input  wire logic [sacts_pkg::PICK_W-1:0]        in_pick,
    input  wire sacts_pkg::q_stat_t                  q_stat,
    output logic                                     q_push,
    output sacts_pkg::req_t                          q_req,
    output logic [((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0]    q_set,
    output logic [((MAX_ASSOC > 1) ? $clog2(MAX_ASSOC) : 1)-1:0]  q_pick
);
    import sacts_pkg::*;

    localparam int SIDX_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WIDX_W = (MAX_ASSOC > 1) ? $clog2(MAX_ASSOC) : 1;
    localparam int SRW    = SIDX_W + 1;
    localparam int WRW    = WIDX_W + 1;
    localparam int CNT_B  = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

    fstate_t              state_reg;
    req_t                 req_reg;
    logic [ADDR_W-1:0]    addr_sh_reg;
    logic [ADDR_W-1:0]    pick_sh_reg;
    logic [SRW-1:0]       set_rem_reg, set_rem_next;
    logic [WRW-1:0]       pick_rem_reg, pick_rem_next;
    logic [CNT_B-1:0]     step_reg;

    // four restoring remainder steps per cycle
    always_comb
    begin
        logic [SRW:0] ts;
        logic [WRW:0] tw;
        set_rem_next  = set_rem_reg;
        pick_rem_next = pick_rem_reg;
        for (int k = 0; k < DIGIT_BITS; k++)
        begin
            ts = {set_rem_next, addr_sh_reg[ADDR_W-1-k]};
            if (ts >= {1'b0, sets_use})
                ts = ts - {1'b0, sets_use};
            set_rem_next = ts[SRW-1:0];
            tw = {pick_rem_next, pick_sh_reg[ADDR_W-1-k]};
            if (tw >= {1'b0, ways_use})
                tw = tw - {1'b0, ways_use};
            pick_rem_next = tw[WRW-1:0];
        end
    end

    assign in_stall = (state_reg != F_IDLE);
    assign q_push   = (state_reg == F_PUSH) && !q_stat.full;
    assign q_req    = req_reg;
    assign q_set    = set_rem_reg[SIDX_W-1:0];
    assign q_pick   = pick_rem_reg[WIDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg      <= in_req;
                        addr_sh_reg  <= in_req.line_addr;
                        pick_sh_reg  <= {{(ADDR_W-PICK_W){1'b0}}, in_pick};
                        set_rem_reg  <= '0;
                        pick_rem_reg <= '0;
                        step_reg     <= '0;
                        state_reg    <= F_DIV;
                    end
                end
                F_DIV:
                begin
                    set_rem_reg  <= set_rem_next;
                    pick_rem_reg <= pick_rem_next;
                    addr_sh_reg  <= addr_sh_reg << DIGIT_BITS;
                    pick_sh_reg  <= pick_sh_reg << DIGIT_BITS;
                    step_reg     <= step_reg + 1'b1;
                    if (step_reg == CNT_B'(DIV_STEPS - 1))
                        state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (!q_stat.full)
                        state_reg <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/sacts_queue.sv -----
`default_nettype none
module sacts_queue #(
    parameter int DATA_W = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire logic [DATA_W-1:0]  push_data,
    input  wire logic               pop,
    output logic [DATA_W-1:0]       pop_data,
    output sacts_pkg::q_stat_t      stat
);
    import sacts_pkg::*;

    logic [DATA_W-1:0] slot_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;

    assign pop_data   = slot_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/sacts_back.sv -----
`default_nettype none
`include "set_assoc_cache_tag_store_defines.svh"
module sacts_back #(
    parameter int MAX_SETS  = 1024,
    parameter int MAX_ASSOC = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [((MAX_ASSOC > 1) ? $clog2(MAX_ASSOC) : 1):0] ways_use,
    input  wire logic                                random_replace,
    input  wire sacts_pkg::q_stat_t                  q_stat,
    input  wire sacts_pkg::req_t                     q_req,
    input  wire logic [((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0]    q_set,
    input  wire logic [((MAX_ASSOC > 1) ? $clog2(MAX_ASSOC) : 1)-1:0]  q_pick,
    output logic                                     q_pop,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     hit,
    output logic                                     evict_valid,
    output logic [sacts_pkg::ADDR_W-1:0]             evict_tag,
    output logic                                     evict_dirty,
    output logic [sacts_pkg::CNT_W-1:0]              read_accesses,
    output logic [sacts_pkg::CNT_W-1:0]              write_accesses,
    output logic [sacts_pkg::CNT_W-1:0]              read_misses,
    output logic [sacts_pkg::CNT_W-1:0]              write_misses,
    output logic [sacts_pkg::CNT_W-1:0]              dirty_evictions
);
    import sacts_pkg::*;

    localparam int SIDX_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WIDX_W = (MAX_ASSOC > 1) ? $clog2(MAX_ASSOC) : 1;
    localparam int WRW    = WIDX_W + 1;
    localparam int CLR_W  = SIDX_W + 1;

    typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_LOOK, B_SCAN, B_COMMIT} bstate_t;

    // valid bits low half, dirty bits high half
    logic [2*MAX_ASSOC-1:0]       vd_mem    [MAX_SETS];
    logic [MAX_ASSOC*ADDR_W-1:0]  tag_mem   [MAX_SETS];
    logic [MAX_ASSOC*STAMP_W-1:0] stamp_mem [MAX_SETS];

    logic [2*MAX_ASSOC-1:0]       vd_row_reg;
    logic [MAX_ASSOC*ADDR_W-1:0]  tag_row_reg;
    logic [MAX_ASSOC*STAMP_W-1:0] stamp_row_reg;

    bstate_t               state_reg;
    req_t                  req_reg;
    logic [SIDX_W-1:0]     set_reg;
    logic [WIDX_W-1:0]     pick_reg;
    logic [WIDX_W-1:0]     victim_reg;
    logic [STAMP_W-1:0]    best_reg;
    logic [WRW-1:0]        scan_reg;
    logic                  full_reg;
    logic [CLR_W-1:0]      clr_reg;

    logic [CNT_W-1:0] rd_acc_reg, wr_acc_reg, rd_miss_reg, wr_miss_reg, dirty_ev_reg;
    logic [CNT_W-1:0] rd_acc_next, wr_acc_next, rd_miss_next, wr_miss_next, dirty_ev_next;

    logic                  out_valid_reg;
    logic                  hit_reg, ev_valid_reg, ev_dirty_reg;
    logic [ADDR_W-1:0]     ev_tag_reg;

    logic                  out_free;
    logic                  mem_re;
    logic                  commit;
    logic                  free_found;
    logic [WIDX_W-1:0]     first_free;
    logic                  hit_any;
    logic [2*MAX_ASSOC-1:0]       vd_new;
    logic [MAX_ASSOC*ADDR_W-1:0]  tag_new;
    logic [MAX_ASSOC*STAMP_W-1:0] stamp_new;
    logic [STAMP_W-1:0]    scan_stamp;
    logic                  ev_dirty_now;

    assign out_free = !out_valid_reg || !out_stall;
    assign q_pop    = (state_reg == B_IDLE) && !q_stat.empty;
    assign mem_re   = q_pop;
    assign commit   = (state_reg == B_COMMIT) && out_free;

    // lowest free way among those in use
    always_comb
    begin
        free_found = 1'b0;
        first_free = '0;
        for (int w = MAX_ASSOC - 1; w >= 0; w--)
        begin
            if ((w < int'(ways_use)) && !vd_row_reg[w])
            begin
                free_found = 1'b1;
                first_free = WIDX_W'(w);
            end
        end
    end

    assign scan_stamp = stamp_row_reg[scan_reg[WIDX_W-1:0]*STAMP_W +: STAMP_W];

    // row update for the commit cycle
    always_comb
    begin
        vd_new    = vd_row_reg;
        tag_new   = tag_row_reg;
        stamp_new = stamp_row_reg;
        hit_any   = 1'b0;
        if (req_reg.opcode == OP_LOOKUP)
        begin
            for (int w = 0; w < MAX_ASSOC; w++)
            begin
                if ((w < int'(ways_use)) && vd_row_reg[w]
                    && (tag_row_reg[w*ADDR_W +: ADDR_W] == req_reg.line_addr))
                begin
                    hit_any = 1'b1;
                    stamp_new[w*STAMP_W +: STAMP_W] = req_reg.time_stamp;
                    if (req_reg.dirty_flag)
                        vd_new[MAX_ASSOC+w] = 1'b1;
                end
            end
        end
        else
        begin
            vd_new[victim_reg]                           = 1'b1;
            vd_new[MAX_ASSOC+int'(victim_reg)]           = req_reg.dirty_flag;
            tag_new[victim_reg*ADDR_W +: ADDR_W]         = req_reg.line_addr;
            stamp_new[victim_reg*STAMP_W +: STAMP_W]     = req_reg.time_stamp;
        end
    end

    assign ev_dirty_now = (req_reg.opcode == OP_INSTALL) && full_reg
                          && vd_row_reg[MAX_ASSOC+int'(victim_reg)];

    always_comb
    begin
        rd_acc_next   = rd_acc_reg;
        wr_acc_next   = wr_acc_reg;
        rd_miss_next  = rd_miss_reg;
        wr_miss_next  = wr_miss_reg;
        dirty_ev_next = dirty_ev_reg;
        if (req_reg.opcode == OP_LOOKUP)
        begin
            if (req_reg.dirty_flag)
            begin
                wr_acc_next = sat_inc(wr_acc_reg);
                if (!hit_any)
                    wr_miss_next = sat_inc(wr_miss_reg);
            end
            else
            begin
                rd_acc_next = sat_inc(rd_acc_reg);
                if (!hit_any)
                    rd_miss_next = sat_inc(rd_miss_reg);
            end
        end
        else if (ev_dirty_now)
        begin
            dirty_ev_next = sat_inc(dirty_ev_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_CLEAR)
            vd_mem[clr_reg[SIDX_W-1:0]] <= '0;
        else if (commit)
            vd_mem[set_reg] <= vd_new;
        if (commit)
        begin
            tag_mem[set_reg]   <= tag_new;
            stamp_mem[set_reg] <= stamp_new;
        end
        if (mem_re)
        begin
            vd_row_reg    <= vd_mem[q_set];
            tag_row_reg   <= tag_mem[q_set];
            stamp_row_reg <= stamp_mem[q_set];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            rd_acc_reg    <= '0;
            wr_acc_reg    <= '0;
            rd_miss_reg   <= '0;
            wr_miss_reg   <= '0;
            dirty_ev_reg  <= '0;
            scan_reg      <= '0;
            victim_reg    <= '0;
            full_reg      <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !commit)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                B_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == CLR_W'(MAX_SETS - 1))
                        state_reg <= B_IDLE;
                end
                B_IDLE:
                begin
                    if (!q_stat.empty)
                    begin
                        req_reg   <= q_req;
                        set_reg   <= q_set;
                        pick_reg  <= q_pick;
                        state_reg <= B_LOOK;
                    end
                end
                B_LOOK:
                begin
                    if (req_reg.opcode == OP_LOOKUP)
                    begin
                        full_reg  <= 1'b0;
                        state_reg <= B_COMMIT;
                    end
                    else if (free_found)
                    begin
                        victim_reg <= first_free;
                        full_reg   <= 1'b0;
                        state_reg  <= B_COMMIT;
                    end
                    else if (random_replace)
                    begin
                        victim_reg <= pick_reg;
                        full_reg   <= 1'b1;
                        state_reg  <= B_COMMIT;
                    end
                    else
                    begin
                        victim_reg <= '0;
                        best_reg   <= stamp_row_reg[STAMP_W-1:0];
                        scan_reg   <= WRW'(1);
                        full_reg   <= 1'b1;
                        state_reg  <= B_SCAN;
                    end
                end
                B_SCAN:
                begin
                    if (scan_reg >= ways_use)
                        state_reg <= B_COMMIT;
                    else
                    begin
                        if (scan_stamp < best_reg)
                        begin
                            best_reg   <= scan_stamp;
                            victim_reg <= scan_reg[WIDX_W-1:0];
                        end
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                B_COMMIT:
                begin
                    if (out_free)
                    begin
                        rd_acc_reg    <= rd_acc_next;
                        wr_acc_reg    <= wr_acc_next;
                        rd_miss_reg   <= rd_miss_next;
                        wr_miss_reg   <= wr_miss_next;
                        dirty_ev_reg  <= dirty_ev_next;
                        out_valid_reg <= 1'b1;
                        hit_reg       <= hit_any;
                        ev_valid_reg  <= (req_reg.opcode == OP_INSTALL) && full_reg;
                        ev_dirty_reg  <= ev_dirty_now;
                        ev_tag_reg    <= ((req_reg.opcode == OP_INSTALL) && full_reg)
                                         ? tag_row_reg[victim_reg*ADDR_W +: ADDR_W]
                                         : '0;
                        state_reg     <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign hit             = hit_reg;
    assign evict_valid     = ev_valid_reg;
    assign evict_tag       = ev_tag_reg;
    assign evict_dirty     = ev_dirty_reg;
    assign read_accesses   = rd_acc_reg;
    assign write_accesses  = wr_acc_reg;
    assign read_misses     = rd_miss_reg;
    assign write_misses    = wr_miss_reg;
    assign dirty_evictions = dirty_ev_reg;

    `SACTS_ASSERT_NOW(a_no_pop_in_clear, state_reg == B_CLEAR, !q_pop, "pop during clear")
    `SACTS_ASSERT_NOW(a_hit_no_evict, out_valid_reg && hit_reg, !ev_valid_reg, "hit evict")
    `SACTS_ASSERT_NOW(a_dirty_valid, out_valid_reg && ev_dirty_reg, ev_valid_reg, "dirty evict")
    `SACTS_ASSERT_NOW(a_victim_ok, state_reg == B_SCAN, {1'b0, victim_reg} < ways_use, "bad victim")
    `SACTS_ASSERT_NEXT(a_commit_frees, commit, state_reg == B_IDLE && out_valid_reg, "commit lost")

endmodule
`default_nettype wire

// ----- rtl/core/set_assoc_cache_tag_store.sv -----
`default_nettype none
// channel   direction  handshake            payload
// in        in         in_valid / in_stall  opcode line_addr dirty_flag time_stamp random_pick
// out       out        out_valid / out_stall hit evict_* and five saturating counters
// cfg       in         cfg_we               cfg_index cfg_wdata
//
// front: radix-16 remainder for set index and random victim, then a push into the queue
// back: row read, classify, then commit; lru victim on a full set adds a scan of ways in use
// the front takes a new beat only after it has pushed the last one
// after reset the back clears valid and dirty bits of all MAX_SETS sets, one set a cycle
// a stalled output holds the back in commit; the 2-entry queue lets the front run ahead
module set_assoc_cache_tag_store #(
    parameter int MAX_SETS  = 1024,
    parameter int MAX_ASSOC = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic                                 opcode,
    input  wire logic [sacts_pkg::ADDR_W-1:0]         line_addr,
    input  wire logic                                 dirty_flag,
    input  wire logic [sacts_pkg::STAMP_W-1:0]        time_stamp,
    input  wire logic [sacts_pkg::PICK_W-1:0]         random_pick,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic                                      hit,
    output logic                                      evict_valid,
    output logic [sacts_pkg::ADDR_W-1:0]              evict_tag,
    output logic                                      evict_dirty,
    output logic [sacts_pkg::CNT_W-1:0]               read_accesses,
    output logic [sacts_pkg::CNT_W-1:0]               write_accesses,
    output logic [sacts_pkg::CNT_W-1:0]               read_misses,
    output logic [sacts_pkg::CNT_W-1:0]               write_misses,
    output logic [sacts_pkg::CNT_W-1:0]               dirty_evictions,
    input  wire logic                                 cfg_we,
    input  wire logic [sacts_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [sacts_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import sacts_pkg::*;

    localparam int SIDX_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WIDX_W = (MAX_ASSOC > 1) ? $clog2(MAX_ASSOC) : 1;
    localparam int SRW    = SIDX_W + 1;
    localparam int WRW    = WIDX_W + 1;
    localparam int Q_W    = $bits(req_t) + SIDX_W + WIDX_W;

    // config registers
    logic [SET_CNT_W-1:0] set_count_reg;
    logic [WAY_CNT_W-1:0] way_count_reg;
    logic                 random_replace_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_count_reg      <= SET_CNT_W'(1024);
            way_count_reg      <= WAY_CNT_W'(16);
            random_replace_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SET_COUNT:      set_count_reg      <= cfg_wdata[SET_CNT_W-1:0];
                CFG_WAY_COUNT:      way_count_reg      <= cfg_wdata[WAY_CNT_W-1:0];
                CFG_RANDOM_REPLACE: random_replace_reg <= cfg_wdata[0];
                default:            ;
            endcase
        end
    end

    // clamp counts to 1..max
    logic [31:0]    sets_wide, ways_wide;
    logic [SRW-1:0] sets_use;
    logic [WRW-1:0] ways_use;

    always_comb
    begin
        if (set_count_reg == '0)
            sets_wide = 32'd1;
        else if (32'(set_count_reg) > 32'(MAX_SETS))
            sets_wide = 32'(MAX_SETS);
        else
            sets_wide = 32'(set_count_reg);
        if (way_count_reg == '0)
            ways_wide = 32'd1;
        else if (32'(way_count_reg) > 32'(MAX_ASSOC))
            ways_wide = 32'(MAX_ASSOC);
        else
            ways_wide = 32'(way_count_reg);
    end

    assign sets_use = sets_wide[SRW-1:0];
    assign ways_use = ways_wide[WRW-1:0];

    // front to queue
    req_t              in_req;
    q_stat_t           q_stat;
    logic              q_push, q_pop;
    req_t              f_req, b_req;
    logic [SIDX_W-1:0] f_set, b_set;
    logic [WIDX_W-1:0] f_pick, b_pick;
    logic [Q_W-1:0]    q_out;

    assign in_req.opcode     = opcode;
    assign in_req.line_addr  = line_addr;
    assign in_req.dirty_flag = dirty_flag;
    assign in_req.time_stamp = time_stamp;

    sacts_front #(
        .MAX_SETS  (MAX_SETS),
        .MAX_ASSOC (MAX_ASSOC)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .sets_use (sets_use),
        .ways_use (ways_use),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_req   (in_req),
        .in_pick  (random_pick),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_req    (f_req),
        .q_set    (f_set),
        .q_pick   (f_pick)
    );

    sacts_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({f_req, f_set, f_pick}),
        .pop       (q_pop),
        .pop_data  (q_out),
        .stat      (q_stat)
    );

    assign {b_req, b_set, b_pick} = q_out;

    sacts_back #(
        .MAX_SETS  (MAX_SETS),
        .MAX_ASSOC (MAX_ASSOC)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .ways_use        (ways_use),
        .random_replace  (random_replace_reg),
        .q_stat          (q_stat),
        .q_req           (b_req),
        .q_set           (b_set),
        .q_pick          (b_pick),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .hit             (hit),
        .evict_valid     (evict_valid),
        .evict_tag       (evict_tag),
        .evict_dirty     (evict_dirty),
        .read_accesses   (read_accesses),
        .write_accesses  (write_accesses),
        .read_misses     (read_misses),
        .write_misses    (write_misses),
        .dirty_evictions (dirty_evictions)
    );

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import sacts_pkg::*;

    localparam int N_SETS = 1024;
    localparam int N_WAYS = 16;
    // clearing pass after reset plus slow beats under heavy stall
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic               op;
        logic [ADDR_W-1:0]  addr;
        logic               dirty;
        logic [STAMP_W-1:0] stamp;
        logic [PICK_W-1:0]  pick;
    } access_t;

    typedef struct packed {
        logic              hit;
        logic              ev_valid;
        logic [ADDR_W-1:0] ev_tag;
        logic              ev_dirty;
        logic [CNT_W-1:0]  rd_acc;
        logic [CNT_W-1:0]  wr_acc;
        logic [CNT_W-1:0]  rd_miss;
        logic [CNT_W-1:0]  wr_miss;
        logic [CNT_W-1:0]  dirty_ev;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic opcode = 1'b0;
    logic [ADDR_W-1:0] line_addr = '0;
    logic dirty_flag = 1'b0;
    logic [STAMP_W-1:0] time_stamp = '0;
    logic [PICK_W-1:0] random_pick = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic hit, evict_valid, evict_dirty;
    logic [ADDR_W-1:0] evict_tag;
    logic [CNT_W-1:0] read_accesses, write_accesses, read_misses, write_misses;
    logic [CNT_W-1:0] dirty_evictions;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    set_assoc_cache_tag_store dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow tag store
    logic              sh_valid [N_SETS*N_WAYS];
    logic              sh_dirty [N_SETS*N_WAYS];
    logic [ADDR_W-1:0] sh_tag   [N_SETS*N_WAYS];
    logic [STAMP_W-1:0] sh_use  [N_SETS*N_WAYS];
    logic [CNT_W-1:0]  c_rd_acc, c_wr_acc, c_rd_miss, c_wr_miss, c_dirty_ev;
    int unsigned       cur_sets = 1024, cur_ways = 16;
    bit                cur_random = 1'b0;

    access_t  pending_beats[$];
    outcome_t expected_outcomes[$];
    bit failed = 1'b0;
    bit driver_quiet = 1'b0;
    bit sink_quiet = 1'b0;
    int hold_off = 0;
    int long_hold = 0;
    bit pause_req = 1'b0;
    int cycles = 0;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1;
    endfunction

    // predicted outcome of one accepted beat, updating the shadow
    function automatic outcome_t predict_access(input access_t a);
        outcome_t r;
        int unsigned sets, ways, base, victim, w;
        logic [STAMP_W-1:0] best;
        sets = (cur_sets == 0) ? 1 : (cur_sets > N_SETS ? N_SETS : cur_sets);
        ways = (cur_ways == 0) ? 1 : (cur_ways > N_WAYS ? N_WAYS : cur_ways);
        base = (a.addr % sets) * N_WAYS;
        r = '0;
        if (a.op == OP_LOOKUP)
        begin
            if (a.dirty) c_wr_acc = bump(c_wr_acc);
            else c_rd_acc = bump(c_rd_acc);
            for (w = 0; w < ways; w++)
                if (sh_valid[base+w] && sh_tag[base+w] == a.addr)
                begin
                    r.hit = 1'b1;
                    sh_use[base+w] = a.stamp;
                    if (a.dirty) sh_dirty[base+w] = 1'b1;
                end
            if (!r.hit)
            begin
                if (a.dirty) c_wr_miss = bump(c_wr_miss);
                else c_rd_miss = bump(c_rd_miss);
            end
        end
        else
        begin
            victim = ways;
            for (w = 0; w < ways; w++)
                if (!sh_valid[base+w] && victim == ways) victim = w;
            if (victim == ways)
            begin
                if (cur_random) victim = a.pick % ways;
                else
                begin
                    victim = 0;
                    best = sh_use[base];
                    for (w = 1; w < ways; w++)
                        if (sh_use[base+w] < best)
                        begin
                            best = sh_use[base+w];
                            victim = w;
                        end
                end
                r.ev_valid = 1'b1;
                r.ev_tag = sh_tag[base+victim];
                r.ev_dirty = sh_dirty[base+victim];
                if (r.ev_dirty) c_dirty_ev = bump(c_dirty_ev);
            end
            sh_valid[base+victim] = 1'b1;
            sh_tag[base+victim] = a.addr;
            sh_dirty[base+victim] = a.dirty;
            sh_use[base+victim] = a.stamp;
        end
        r.rd_acc = c_rd_acc;
        r.wr_acc = c_wr_acc;
        r.rd_miss = c_rd_miss;
        r.wr_miss = c_wr_miss;
        r.dirty_ev = c_dirty_ev;
        return r;
    endfunction

    // driver: beats leave the queue, random gaps between them
    int gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                void'(pending_beats.pop_front());
                expected_outcomes.push_back(predict_access({opcode, line_addr, dirty_flag,
                                                            time_stamp, random_pick}));
            end
            if (in_valid && in_stall)
                ;
            else if (gap > 0)
            begin
                gap <= gap - 1;
                in_valid <= 1'b0;
            end
            else if (!driver_quiet && $urandom_range(0, 9) == 0)
            begin
                gap <= $urandom_range(0, 17);
                in_valid <= 1'b0;
            end
            else if (pending_beats.size() > 0 && !pause_req)
            begin
                access_t nb;
                nb = pending_beats[0];
                in_valid <= 1'b1;
                opcode <= nb.op;
                line_addr <= nb.addr;
                dirty_flag <= nb.dirty;
                time_stamp <= nb.stamp;
                random_pick <= nb.pick;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor and sink stall
    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    failed = 1'b1;
                end
                else
                begin
                    e = expected_outcomes.pop_front();
                    if (hit !== e.hit)
                    begin
                        $error("hit exp %0h got %0h", e.hit, hit); failed = 1'b1;
                    end
                    if (evict_valid !== e.ev_valid)
                    begin
                        $error("evict_valid exp %0h got %0h", e.ev_valid, evict_valid);
                        failed = 1'b1;
                    end
                    if (evict_tag !== e.ev_tag)
                    begin
                        $error("evict_tag exp %0h got %0h", e.ev_tag, evict_tag);
                        failed = 1'b1;
                    end
                    if (evict_dirty !== e.ev_dirty)
                    begin
                        $error("evict_dirty exp %0h got %0h", e.ev_dirty, evict_dirty);
                        failed = 1'b1;
                    end
                    if (read_accesses !== e.rd_acc)
                    begin
                        $error("read_accesses exp %0h got %0h", e.rd_acc, read_accesses);
                        failed = 1'b1;
                    end
                    if (write_accesses !== e.wr_acc)
                    begin
                        $error("write_accesses exp %0h got %0h", e.wr_acc, write_accesses);
                        failed = 1'b1;
                    end
                    if (read_misses !== e.rd_miss)
                    begin
                        $error("read_misses exp %0h got %0h", e.rd_miss, read_misses);
                        failed = 1'b1;
                    end
                    if (write_misses !== e.wr_miss)
                    begin
                        $error("write_misses exp %0h got %0h", e.wr_miss, write_misses);
                        failed = 1'b1;
                    end
                    if (dirty_evictions !== e.dirty_ev)
                    begin
                        $error("dirty_evictions exp %0h got %0h", e.dirty_ev, dirty_evictions);
                        failed = 1'b1;
                    end
                end
            end
            // long hold-off takes priority, counted here
            if (long_hold > 0)
            begin
                long_hold <= long_hold - 1;
                out_stall <= 1'b1;
            end
            else if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                out_stall <= 1'b1;
            end
            else if (!sink_quiet && $urandom_range(0, 9) == 0)
            begin
                hold_off <= $urandom_range(0, 17);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    logic [31:0] stamp_now = 0;

    function automatic access_t mk(input logic op, input logic [31:0] a, input logic d,
                                   input logic [31:0] s, input logic [15:0] p);
        return {op, a, d, s, p};
    endfunction

    task automatic settle();
        while (pending_beats.size() != 0 || in_valid || expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int unsigned val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SET_COUNT: cur_sets = val & 32'h7FF;
            CFG_WAY_COUNT: cur_ways = val & 32'h1F;
            default: cur_random = val[0];
        endcase
    endtask

    task automatic apply_setting(input int unsigned s, input int unsigned w, input bit r);
        settle();
        write_reg(CFG_SET_COUNT, s);
        write_reg(CFG_WAY_COUNT, w);
        write_reg(CFG_RANDOM_REPLACE, r);
    endtask

    // random phase: a small pool of addresses so lookups hit and sets fill
    task automatic random_phase(input int n, input int pool);
        logic [31:0] addr_pool[16];
        access_t a;
        for (int i = 0; i < 16; i++)
            addr_pool[i] = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, pool);
        for (int i = 0; i < n; i++)
        begin
            stamp_now += $urandom_range(0, 3);
            a = mk($urandom_range(0, 2) == 0, addr_pool[$urandom_range(0, 15)],
                   1'($urandom_range(0, 1)), ($urandom_range(0, 7) == 0) ? $urandom : stamp_now,
                   16'($urandom));
            if ($urandom_range(0, 9) == 0) a.addr = $urandom;
            pending_beats.push_back(a);
        end
    endtask

    initial
    begin
        for (int i = 0; i < N_SETS*N_WAYS; i++)
        begin
            sh_valid[i] = 1'b0;
            sh_dirty[i] = 1'b0;
            sh_tag[i] = '0;
            sh_use[i] = '0;
        end
        c_rd_acc = 0; c_wr_acc = 0; c_rd_miss = 0; c_wr_miss = 0; c_dirty_ev = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed at reset values: miss, install, hit, extremes of fields
        pending_beats.push_back(mk(OP_LOOKUP, 32'h0, 1'b0, 32'h0, 16'h0));
        pending_beats.push_back(mk(OP_INSTALL, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 16'hFFFF));
        pending_beats.push_back(mk(OP_LOOKUP, 32'hFFFF_FFFF, 1'b0, 32'h5, 16'h0));
        pending_beats.push_back(mk(OP_LOOKUP, 32'hFFFF_FFFF, 1'b1, 32'h6, 16'h0));
        pending_beats.push_back(mk(OP_INSTALL, 32'h0, 1'b0, 32'h0, 16'h0));
        // duplicate install, then a write lookup refreshes both copies
        pending_beats.push_back(mk(OP_INSTALL, 32'h0, 1'b1, 32'h1, 16'h0));
        pending_beats.push_back(mk(OP_LOOKUP, 32'h0, 1'b1, 32'h9, 16'h0));
        // long receiver hold-off past the clearing pass: block fills and stalls its input
        long_hold = 1500;
        for (int i = 0; i < 8; i++)
            pending_beats.push_back(mk(OP_LOOKUP, i * 1024, 1'b0, i, 16'h0));

        // one set, two ways, lru: ties and evictions of dirty lines
        apply_setting(1, 2, 1'b0);
        pending_beats.push_back(mk(OP_INSTALL, 32'h10, 1'b1, 32'h7, 16'h0));
        pending_beats.push_back(mk(OP_INSTALL, 32'h11, 1'b0, 32'h7, 16'h0));
        pending_beats.push_back(mk(OP_INSTALL, 32'h12, 1'b0, 32'h8, 16'h0));
        pending_beats.push_back(mk(OP_INSTALL, 32'h13, 1'b1, 32'h3, 16'h0));
        pending_beats.push_back(mk(OP_LOOKUP, 32'h13, 1'b0, 32'h20, 16'h0));

        // out-of-range register values and random victim
        apply_setting(0, 0, 1'b1);
        pending_beats.push_back(mk(OP_INSTALL, 32'h5, 1'b1, 32'h1, 16'h1));
        pending_beats.push_back(mk(OP_INSTALL, 32'h6, 1'b0, 32'h2, 16'hFFFF));
        apply_setting(2047, 31, 1'b1);
        pending_beats.push_back(mk(OP_INSTALL, 32'h400, 1'b0, 32'h2, 16'h3));
        pending_beats.push_back(mk(OP_LOOKUP, 32'h400, 1'b0, 32'h2, 16'h3));

        // sender pause until everything drained
        settle();

        apply_setting(4, 4, 1'b0);
        random_phase(130, 40);
        apply_setting(3, 16, 1'b1);
        random_phase(120, 120);
        apply_setting(1, 1, 1'b0);
        random_phase(60, 10);
        apply_setting(1024, 16, 1'b0);
        random_phase(60, 64);
        apply_setting(7, 3, 1'b1);
        random_phase(80, 50);
        // last stretch: no idling
        settle();
        driver_quiet = 1'b1;
        sink_quiet = 1'b1;
        apply_setting(2, 5, 1'b0);
        random_phase(100, 30);
        settle();
        if (!failed)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+rtl/core
rtl/core/sacts_pkg.sv
rtl/core/sacts_front.sv
rtl/core/sacts_queue.sv
rtl/core/sacts_back.sv
rtl/core/set_assoc_cache_tag_store.sv
verif/tb_top.sv
